### rtl/gradient_fifo_word_decoder_defines.svh
// ----------------------------------------------------------------------------
// Gradient FIFO word decoder - assertion macros
// Shared concurrent check forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_FIFO_WORD_DECODER_DEFINES_SVH
`define GRADIENT_FIFO_WORD_DECODER_DEFINES_SVH

// Same-cycle implication.
`define GFWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GFWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gfwd_pkg.sv
// ----------------------------------------------------------------------------
// gfwd_pkg
// Opcodes, field widths and the decoded-word struct of the FIFO word decoder.
// ----------------------------------------------------------------------------
package gfwd_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DUR_W   = 26;
  localparam int unsigned REP_W   = 16;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned GATE_W  = 12;
  localparam int unsigned STORE_W = 20;
  localparam int unsigned USER_W  = 16;
  localparam int unsigned OP_W    = 5;
  localparam int unsigned OUT_W   = 136;  // 133 bits of fields, padded to bytes

  // opcodes, word bits 30:26
  localparam logic [OP_W-1:0] OP_DURATION = 5'd1;
  localparam logic [OP_W-1:0] OP_AMP_X    = 5'd2;
  localparam logic [OP_W-1:0] OP_AMP_Y    = 5'd3;
  localparam logic [OP_W-1:0] OP_AMP_Z    = 5'd4;
  localparam logic [OP_W-1:0] OP_AMP_B0   = 5'd5;
  localparam logic [OP_W-1:0] OP_SCL_X    = 5'd6;
  localparam logic [OP_W-1:0] OP_SCL_Y    = 5'd7;
  localparam logic [OP_W-1:0] OP_SCL_Z    = 5'd8;
  localparam logic [OP_W-1:0] OP_SCL_B0   = 5'd9;
  localparam logic [OP_W-1:0] OP_ECC_X    = 5'd10;
  localparam logic [OP_W-1:0] OP_ECC_Y    = 5'd11;
  localparam logic [OP_W-1:0] OP_ECC_Z    = 5'd12;
  localparam logic [OP_W-1:0] OP_ECC_B0   = 5'd13;
  localparam logic [OP_W-1:0] OP_SHIM     = 5'd14;
  localparam logic [OP_W-1:0] OP_GATES    = 5'd15;
  localparam logic [OP_W-1:0] OP_USER     = 5'd16;
  localparam logic [OP_W-1:0] OP_REPEAT   = 5'd17;

  // what one word asks of the held state
  typedef struct packed {
    logic               latch;
    logic               unknown;
    logic               dur_wr;
    logic [DUR_W-1:0]   dur_val;
    logic               rep_wr;
    logic [REP_W-1:0]   rep_val;
    logic [CNT_W-1:0]   cnt_val;   // zero when the word carries no count
    logic               gate_wr;
    logic [GATE_W-1:0]  gate_val;
    logic [STORE_W-1:0] stored;
    logic [USER_W-1:0]  user;
  } gfwd_dec_t;

endpackage

### rtl/gfwd_decode.sv
// ----------------------------------------------------------------------------
// gfwd_decode
// Splits one FIFO word into latch, opcode and data and says what it updates.
// ----------------------------------------------------------------------------
module gfwd_decode import gfwd_pkg::*; (
  input  logic              clear,
  input  logic [WORD_W-1:0] word,
  output gfwd_dec_t         dec
);

  logic [OP_W-1:0]  op;
  logic [DUR_W-1:0] d;

  assign op = word[30:26];
  assign d  = word[DUR_W-1:0];

  always_comb begin
    dec          = '0;
    dec.dur_val  = d;
    dec.rep_val  = d[24:9];
    dec.gate_val = d[GATE_W-1:0];
    if (!clear) begin
      dec.latch = word[31];
      unique case (op)
        OP_DURATION: begin
          dec.dur_wr = 1'b1;
        end
        OP_AMP_X, OP_AMP_Y, OP_AMP_Z, OP_AMP_B0,
        OP_SCL_X, OP_SCL_Y, OP_SCL_Z, OP_SCL_B0: begin
          dec.stored  = {4'b0, d[15:0]};
          dec.cnt_val = d[24:16];
        end
        OP_ECC_X, OP_ECC_Y, OP_ECC_Z, OP_ECC_B0: begin
          dec.stored = {4'b0, d[15:0]};
        end
        OP_SHIM: begin
          dec.stored = d[STORE_W-1:0];
        end
        OP_GATES: begin
          dec.gate_wr = 1'b1;
        end
        OP_USER: begin
          dec.user = d[USER_W-1:0];
        end
        OP_REPEAT: begin
          // repeat and short duration share data bit 9
          dec.rep_wr  = 1'b1;
          dec.dur_wr  = 1'b1;
          dec.dur_val = {16'b0, d[9:0]};
        end
        default: begin
          dec.unknown = 1'b1;
        end
      endcase
    end
  end

endmodule

### rtl/gradient_fifo_word_decoder.sv
// ----------------------------------------------------------------------------
// gradient_fifo_word_decoder
// Decodes gradient FIFO words, tracks the held timing state and keeps a
// wrapping total of latched duration ticks.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                          | tuser
//  --------+-----+--------------------------------+------------------------
//  in_     | in  | [31:0] instr_word              | [0] mode (1 = clear)
//  out_    | out | 133 bits of result fields      | -
//
//  One word per cycle sustained while out_ is ready. A word accepted on in_
//  lands in the input register; from there decode, hold update, a 26x16
//  multiply and the 32-bit add into the total settle into the state and
//  result registers, and out_tvalid rises as they load.
//  rst_n (synchronous) zeroes all held state, the total and both valid flags.
//  A stalled out_ channel holds the result; one more word waits in the
//  input register before in_tready drops.
// ----------------------------------------------------------------------------
module gradient_fifo_word_decoder import gfwd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // [31:0] instr_word
  input  logic             in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  logic             out_tready,
  // [31:0] total_duration, [32] word_latched, [33] unknown_opcode,
  // [59:34] held_duration, [75:60] held_repeat, [84:76] held_count,
  // [96:85] held_gates, [116:97] stored_value, [132:117] user_data,
  // [135:133] zero
  output logic [OUT_W-1:0] out_tdata
);

`include "gradient_fifo_word_decoder_defines.svh"

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_mode_r;
  logic [WORD_W-1:0] s1_word_r;

  // held state
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [GATE_W-1:0] gate_r, gate_nxt;
  logic [31:0]       total_r, total_nxt;

  // result register (flag and per-word fields; held fields come from state)
  logic               out_valid_r, out_valid_nxt;
  logic               latched_r, unknown_r;
  logic [STORE_W-1:0] stored_r;
  logic [USER_W-1:0]  user_r;

  logic        in_fire, s1_adv, s1_fire;
  gfwd_dec_t   dec;
  logic [REP_W-1:0] rep_pre, mult;
  logic [41:0]      prod;

  // handshake: result register frees the input register, which frees in_
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && s1_adv;

  gfwd_decode u_decode (
    .clear (s1_mode_r),
    .word  (s1_word_r),
    .dec   (dec)
  );

  always_comb begin
    dur_nxt  = dec.dur_wr  ? dec.dur_val  : dur_r;
    gate_nxt = dec.gate_wr ? dec.gate_val : gate_r;
    rep_pre  = dec.rep_wr  ? dec.rep_val  : rep_r;

    // smallest nonzero count wins; any nonzero count replaces a zero one
    if ((dec.cnt_val != '0) && ((cnt_r == '0) || (dec.cnt_val < cnt_r))) begin
      cnt_nxt = dec.cnt_val;
    end else begin
      cnt_nxt = cnt_r;
    end

    // multiplier: repeat capped by a nonzero count, else count, else one.
    // A pending repeat with zero count gives zero; a latched word still consumes it.
    rep_nxt = rep_pre;
    if (rep_pre != '0) begin
      if ((cnt_nxt != '0) && (rep_pre < {7'b0, cnt_nxt})) begin
        mult = rep_pre;
      end else begin
        mult = {7'b0, cnt_nxt};
      end
      if (dec.latch) begin
        rep_nxt = '0;
      end
    end else if (cnt_nxt != '0) begin
      mult = {7'b0, cnt_nxt};
    end else begin
      mult = 16'd1;
    end

    prod = {16'b0, dur_nxt} * {26'b0, mult};

    priority if (s1_mode_r) begin
      total_nxt = '0;
    end else if (dec.latch) begin
      total_nxt = total_r + prod[31:0];
    end else begin
      total_nxt = total_r;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dur_r       <= '0;
      rep_r       <= '0;
      cnt_r       <= '0;
      gate_r      <= '0;
      total_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        dur_r   <= dur_nxt;
        rep_r   <= rep_nxt;
        cnt_r   <= cnt_nxt;
        gate_r  <= gate_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_tuser;
      s1_word_r <= in_tdata;
    end
    if (s1_fire) begin
      latched_r <= dec.latch;
      unknown_r <= dec.unknown;
      stored_r  <= dec.stored;
      user_r    <= dec.user;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, user_r, stored_r, gate_r, cnt_r, rep_r, dur_r,
                       unknown_r, latched_r, total_r};

  // checks
  `GFWD_ASSERT_NOW(a_unknown_no_payload, out_valid_r && unknown_r,
    (stored_r == '0) && (user_r == '0), "unknown opcode carried a payload")
  `GFWD_ASSERT_NOW(a_latch_clears_repeat, out_valid_r && latched_r,
    rep_r == '0, "repeat count left after a latched word")
  `GFWD_ASSERT_NEXT(a_count_sticks, cnt_r != '0,
    cnt_r != '0, "held count fell back to zero")
  `GFWD_ASSERT_NEXT(a_total_hold, s1_fire && !s1_mode_r && !s1_word_r[31],
    total_r == $past(total_r), "total moved on an unlatched word")
  `GFWD_ASSERT_NOW(a_ready_empty, !s1_valid_r,
    in_tready, "input register empty but not ready")

endmodule
